FILE: rtl/core/sjvp_pkg.sv
// Shared types and constants for the strict JSON verdict parser.
// No dependencies; imported by every module of the block.
`default_nettype none
package sjvp_pkg;

   localparam int QueueDepth = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_response;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_byte_valid;
      logic       response_done;
      logic       response_ok;
      logic       verdict_pass;
      logic       last_of_run;
   } rsp_type;

   // A work entry between the parser front and the result emitter.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      nbytes;
      logic            done;
      logic            ok;
      logic            pass;
   } work_type;

   typedef enum logic [3:0] {
      PH_OPEN, PH_KEY_QUOTE, PH_COLON, PH_VALUE_QUOTE, PH_AFTER_MEMBER, PH_TRAIL,
      PH_STR, PH_ESC, PH_HEX, PH_LOW_BS, PH_LOW_U, PH_LOW_HEX, PH_UTF8
   } phase_type;

   typedef enum logic [1:0] {
      TGT_NONE, TGT_VERDICT, TGT_RATIONALE
   } target_type;

   function automatic logic [7:0] verdict_char(input logic [3:0] pos);
      case (pos)
         4'd0: verdict_char = "v";
         4'd1: verdict_char = "e";
         4'd2: verdict_char = "r";
         4'd3: verdict_char = "d";
         4'd4: verdict_char = "i";
         4'd5: verdict_char = "c";
         4'd6: verdict_char = "t";
         default: verdict_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] rationale_char(input logic [3:0] pos);
      case (pos)
         4'd0: rationale_char = "r";
         4'd1: rationale_char = "a";
         4'd2: rationale_char = "t";
         4'd3: rationale_char = "i";
         4'd4: rationale_char = "o";
         4'd5: rationale_char = "n";
         4'd6: rationale_char = "a";
         4'd7: rationale_char = "l";
         4'd8: rationale_char = "e";
         default: rationale_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] pass_char(input logic [2:0] pos);
      case (pos)
         3'd0: pass_char = "p";
         3'd1: pass_char = "a";
         3'd2: pass_char = "s";
         3'd3: pass_char = "s";
         default: pass_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] fail_char(input logic [2:0] pos);
      case (pos)
         3'd0: fail_char = "f";
         3'd1: fail_char = "a";
         3'd2: fail_char = "i";
         3'd3: fail_char = "l";
         default: fail_char = 8'h00;
      endcase
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sjvp_front.sv
// Parser front: accepts request bytes, runs the grammar and decodes strings.
// Pushes decoded rationale bytes and the final status into a work entry.
// Depends on sjvp_pkg.
`default_nettype none
module sjvp_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  sjvp_pkg::req_type   req_data,
   output logic                wr_en,
   output sjvp_pkg::work_type  wr_data,
   input  wire                 q_full
);
   import sjvp_pkg::*;

   phase_type   phase_ff, phase_in;
   target_type  tgt_ff, tgt_in;
   logic        mcount_ff, mcount_in, seen_v_ff, seen_v_in, seen_r_ff, seen_r_in;
   logic [3:0]  kpos_ff, kpos_in;
   logic [1:0]  kcand_ff, kcand_in;
   logic [2:0]  vpos_ff, vpos_in;
   logic [1:0]  vcand_ff, vcand_in;
   logic        rne_ff, rne_in, passed_ff, passed_in, err_ff, err_in;
   logic [15:0] hacc_ff, hacc_in;
   logic [1:0]  hcnt_ff, hcnt_in;
   logic [9:0]  hsur_ff, hsur_in;
   logic [1:0]  urem_ff, urem_in;
   logic [2:0]  urng_ff, urng_in;

   logic        accept;
   logic [7:0]  b;
   logic [3:0][7:0] dec;
   logic [2:0]  ndec;
   logic        ws, ok;
   logic [4:0]  hexd;
   logic [15:0] hv;
   logic [20:0] scal;
   logic [7:0]  rlo, rhi;
   work_type    w;

   assign req_stall = q_full;
   assign accept = req_valid && !q_full;
   assign b = req_data.data_byte;
   assign ws = (b == 8'h20) || (b == 8'h0a) || (b == 8'h0d) || (b == 8'h09);

   always_comb begin
      if (b >= "0" && b <= "9") begin
         hexd = {1'b0, b[3:0]};
      end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
         hexd = {1'b0, b[3:0] + 4'd9};
      end else begin
         hexd = 5'h10;
      end
      hv = {hacc_ff[11:0], hexd[3:0]};
      scal = 21'h10000 + {1'b0, hsur_ff, hv[9:0]};
      case (urng_ff)
         3'd1: begin rlo = 8'ha0; rhi = 8'hbf; end
         3'd2: begin rlo = 8'h80; rhi = 8'h9f; end
         3'd3: begin rlo = 8'h90; rhi = 8'hbf; end
         3'd4: begin rlo = 8'h80; rhi = 8'h8f; end
         default: begin rlo = 8'h80; rhi = 8'hbf; end
      endcase
   end

   always_comb begin
      logic [3:0]  kp;
      logic [1:0]  kc;
      logic [2:0]  vp;
      logic [1:0]  vc;
      logic        e;
      logic [3:0][7:0] enc;
      logic [2:0]  nenc;
      logic        do_scalar;
      logic [20:0] s;
      phase_in = phase_ff; tgt_in = tgt_ff; mcount_in = mcount_ff;
      seen_v_in = seen_v_ff; seen_r_in = seen_r_ff; kpos_in = kpos_ff;
      kcand_in = kcand_ff; vpos_in = vpos_ff; vcand_in = vcand_ff;
      rne_in = rne_ff; passed_in = passed_ff; err_in = err_ff;
      hacc_in = hacc_ff; hcnt_in = hcnt_ff; hsur_in = hsur_ff;
      urem_in = urem_ff; urng_in = urng_ff;
      dec = '0; ndec = 3'd0; do_scalar = 1'b0; s = '0;
      enc = '0; nenc = 3'd0;
      if (req_data.byte_present && !err_ff &&
          !((phase_ff == PH_OPEN || phase_ff == PH_KEY_QUOTE || phase_ff == PH_COLON ||
             phase_ff == PH_VALUE_QUOTE || phase_ff == PH_AFTER_MEMBER ||
             phase_ff == PH_TRAIL) && ws)) begin
         case (phase_ff)
            PH_OPEN: begin
               if (b == "{") phase_in = PH_KEY_QUOTE; else err_in = 1'b1;
            end
            PH_KEY_QUOTE: begin
               if (b != "\"") begin
                  err_in = 1'b1;
               end else begin
                  kpos_in = 4'd0; kcand_in = 2'b11; tgt_in = TGT_NONE;
                  phase_in = PH_STR;
               end
            end
            PH_COLON: begin
               if (b == ":") phase_in = PH_VALUE_QUOTE; else err_in = 1'b1;
            end
            PH_VALUE_QUOTE: begin
               if (b != "\"") begin
                  err_in = 1'b1;
               end else begin
                  vpos_in = 3'd0; vcand_in = 2'b11; phase_in = PH_STR;
               end
            end
            PH_AFTER_MEMBER: begin
               if (!mcount_ff && b == ",") begin
                  mcount_in = 1'b1; phase_in = PH_KEY_QUOTE;
               end else if (mcount_ff && b == "}") begin
                  phase_in = PH_TRAIL;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_STR: begin
               if (b == "\"") begin
                  if (tgt_ff == TGT_NONE) begin
                     if (kcand_ff[0] && kpos_ff == 4'd7) begin
                        if (seen_v_ff) err_in = 1'b1;
                        else begin
                           seen_v_in = 1'b1; tgt_in = TGT_VERDICT; phase_in = PH_COLON;
                        end
                     end else if (kcand_ff[1] && kpos_ff == 4'd9) begin
                        if (seen_r_ff) err_in = 1'b1;
                        else begin
                           seen_r_in = 1'b1; tgt_in = TGT_RATIONALE; phase_in = PH_COLON;
                        end
                     end else begin
                        err_in = 1'b1;
                     end
                  end else if (tgt_ff == TGT_VERDICT) begin
                     if (vcand_ff[0] && vpos_ff == 3'd4) begin
                        passed_in = 1'b1; tgt_in = TGT_NONE; phase_in = PH_AFTER_MEMBER;
                     end else if (vcand_ff[1] && vpos_ff == 3'd4) begin
                        passed_in = 1'b0; tgt_in = TGT_NONE; phase_in = PH_AFTER_MEMBER;
                     end else begin
                        err_in = 1'b1;
                     end
                  end else if (!rne_ff) begin
                     err_in = 1'b1;
                  end else begin
                     tgt_in = TGT_NONE; phase_in = PH_AFTER_MEMBER;
                  end
               end else if (b < 8'h20) begin
                  err_in = 1'b1;
               end else if (b == "\\") begin
                  phase_in = PH_ESC;
               end else if (b < 8'h80) begin
                  dec[0] = b; ndec = 3'd1;
               end else begin
                  phase_in = PH_UTF8; dec[0] = b; ndec = 3'd1; urng_in = 3'd0;
                  if (b >= 8'hc2 && b <= 8'hdf) urem_in = 2'd1;
                  else if (b == 8'he0) begin urem_in = 2'd2; urng_in = 3'd1; end
                  else if (b == 8'hed) begin urem_in = 2'd2; urng_in = 3'd2; end
                  else if (b >= 8'he1 && b <= 8'hef) urem_in = 2'd2;
                  else if (b == 8'hf0) begin urem_in = 2'd3; urng_in = 3'd3; end
                  else if (b >= 8'hf1 && b <= 8'hf3) urem_in = 2'd3;
                  else if (b == 8'hf4) begin urem_in = 2'd3; urng_in = 3'd4; end
                  else begin
                     err_in = 1'b1; phase_in = phase_ff; ndec = 3'd0; urng_in = urng_ff;
                  end
               end
            end
            PH_ESC: begin
               phase_in = PH_STR; ndec = 3'd1;
               case (b)
                  "\"": dec[0] = 8'h22;
                  "\\": dec[0] = 8'h5c;
                  "/":  dec[0] = 8'h2f;
                  "b":  dec[0] = 8'h08;
                  "f":  dec[0] = 8'h0c;
                  "n":  dec[0] = 8'h0a;
                  "r":  dec[0] = 8'h0d;
                  "t":  dec[0] = 8'h09;
                  "u": begin
                     ndec = 3'd0; hcnt_in = 2'd0; hacc_in = 16'd0; phase_in = PH_HEX;
                  end
                  default: begin
                     ndec = 3'd0; err_in = 1'b1;
                  end
               endcase
            end
            PH_HEX, PH_LOW_HEX: begin
               if (hexd[4]) begin
                  err_in = 1'b1;
               end else if (hcnt_ff != 2'd3) begin
                  hacc_in = hv; hcnt_in = hcnt_ff + 2'd1;
               end else begin
                  hacc_in = 16'd0; hcnt_in = 2'd0;
                  if (phase_ff == PH_HEX) begin
                     if (hv[15:10] == 6'b110110) begin
                        hsur_in = hv[9:0]; phase_in = PH_LOW_BS;
                     end else if (hv[15:10] == 6'b110111) begin
                        err_in = 1'b1;
                     end else begin
                        phase_in = PH_STR; do_scalar = 1'b1; s = {5'd0, hv};
                     end
                  end else if (hv[15:10] != 6'b110111) begin
                     err_in = 1'b1;
                  end else begin
                     phase_in = PH_STR; do_scalar = 1'b1; s = scal;
                  end
               end
            end
            PH_LOW_BS: begin
               if (b == "\\") phase_in = PH_LOW_U; else err_in = 1'b1;
            end
            PH_LOW_U: begin
               if (b != "u") begin
                  err_in = 1'b1;
               end else begin
                  hcnt_in = 2'd0; hacc_in = 16'd0; phase_in = PH_LOW_HEX;
               end
            end
            PH_UTF8: begin
               if (b < rlo || b > rhi) begin
                  err_in = 1'b1;
               end else begin
                  dec[0] = b; ndec = 3'd1; urng_in = 3'd0;
                  urem_in = urem_ff - 2'd1;
                  if (urem_ff <= 2'd1) begin
                     urem_in = 2'd0; phase_in = PH_STR;
                  end
               end
            end
            PH_TRAIL: err_in = 1'b1;
            default: err_in = 1'b1;
         endcase
         if (do_scalar) begin
            if (s <= 21'h7f) begin
               enc[0] = s[7:0]; nenc = 3'd1;
            end else if (s <= 21'h7ff) begin
               enc[0] = {3'b110, s[10:6]}; enc[1] = {2'b10, s[5:0]}; nenc = 3'd2;
            end else if (s <= 21'hffff) begin
               enc[0] = {4'b1110, s[15:12]}; enc[1] = {2'b10, s[11:6]};
               enc[2] = {2'b10, s[5:0]}; nenc = 3'd3;
            end else begin
               enc[0] = {5'b11110, s[20:18]}; enc[1] = {2'b10, s[17:12]};
               enc[2] = {2'b10, s[11:6]}; enc[3] = {2'b10, s[5:0]}; nenc = 3'd4;
            end
            dec = enc; ndec = nenc;
         end
      end
      // Feed decoded bytes through the key or verdict matcher, or collect rationale bytes into the work entry.
      w = '0;
      kp = kpos_in; kc = kcand_in; vp = vpos_in; vc = vcand_in; e = err_in;
      for (int i = 0; i < 4; i++) begin
         if (i < 32'(ndec) && !e) begin
            if (tgt_ff == TGT_NONE) begin
               if (kc[0] && !(kp < 4'd7 && verdict_char(kp) == dec[i])) kc[0] = 1'b0;
               if (kc[1] && !(kp < 4'd9 && rationale_char(kp) == dec[i])) kc[1] = 1'b0;
               if (kp < 4'd15) kp = kp + 4'd1;
               if (kc == 2'b00) e = 1'b1;
            end else if (tgt_ff == TGT_VERDICT) begin
               if (vc[0] && !(vp < 3'd4 && pass_char(vp) == dec[i])) vc[0] = 1'b0;
               if (vc[1] && !(vp < 3'd4 && fail_char(vp) == dec[i])) vc[1] = 1'b0;
               if (vp < 3'd7) vp = vp + 3'd1;
               if (vc == 2'b00) e = 1'b1;
            end else begin
               w.bytes[w.nbytes[1:0]] = dec[i];
               w.nbytes = w.nbytes + 3'd1;
               rne_in = 1'b1;
            end
         end
      end
      kpos_in = kp; kcand_in = kc; vpos_in = vp; vcand_in = vc; err_in = e;
      ok = !err_in && phase_in == PH_TRAIL;
      w.done = req_data.end_of_response;
      w.ok = ok;
      w.pass = ok && passed_in;
   end

   assign wr_data = w;
   assign wr_en = accept && (w.done || w.nbytes != 3'd0);

   always_ff @(posedge clock) begin
      if (reset || (accept && req_data.end_of_response)) begin
         phase_ff <= PH_OPEN; tgt_ff <= TGT_NONE; mcount_ff <= 1'b0;
         seen_v_ff <= 1'b0; seen_r_ff <= 1'b0; kpos_ff <= 4'd0; kcand_ff <= 2'b11;
         vpos_ff <= 3'd0; vcand_ff <= 2'b11; rne_ff <= 1'b0; passed_ff <= 1'b0;
         err_ff <= 1'b0; hacc_ff <= 16'd0; hcnt_ff <= 2'd0; hsur_ff <= 10'd0;
         urem_ff <= 2'd0; urng_ff <= 3'd0;
      end else if (accept) begin
         phase_ff <= phase_in; tgt_ff <= tgt_in; mcount_ff <= mcount_in;
         seen_v_ff <= seen_v_in; seen_r_ff <= seen_r_in; kpos_ff <= kpos_in;
         kcand_ff <= kcand_in; vpos_ff <= vpos_in; vcand_ff <= vcand_in;
         rne_ff <= rne_in; passed_ff <= passed_in; err_ff <= err_in;
         hacc_ff <= hacc_in; hcnt_ff <= hcnt_in; hsur_ff <= hsur_in;
         urem_ff <= urem_in; urng_ff <= urng_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (accept && err_ff && !req_data.end_of_response) |-> (wr_data.nbytes == 3'd0))
      else $error("bytes decoded after an error");
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.end_of_response) |=> (phase_ff == PH_OPEN && !err_ff))
      else $error("parser not cleared after end of response");
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !q_full)
      else $error("write into a full queue");
endmodule
`default_nettype wire

FILE: rtl/core/sjvp_queue.sv
// Short FIFO of work entries between parser front and result emitter.
// Depends on sjvp_pkg.
`default_nettype none
module sjvp_queue #(
   parameter int Depth = sjvp_pkg::QueueDepth
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 wr_en,
   input  sjvp_pkg::work_type  wr_data,
   output logic                full,
   input  wire                 rd_en,
   output sjvp_pkg::work_type  rd_data,
   output logic                empty
);
   import sjvp_pkg::*;
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   work_type         mem_ff [Depth];
   logic [AW-1:0]    wp_ff, rp_ff;
   logic [AW:0]      cnt_ff;

   assign full = cnt_ff == (AW+1)'(Depth);
   assign empty = cnt_ff == '0;
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= (wp_ff == AW'(Depth - 1)) ? '0 : wp_ff + 1'b1;
         if (rd_en) rp_ff <= (rp_ff == AW'(Depth - 1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(wr_en) - (AW+1)'(rd_en);
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/sjvp_back.sv
// Result emitter: turns each work entry into rationale byte responses and a status.
// Depends on sjvp_pkg.
`default_nettype none
module sjvp_back (
   input  wire                 clock,
   input  wire                 reset,
   input  sjvp_pkg::work_type  rd_data,
   input  wire                 empty,
   output logic                rd_en,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output sjvp_pkg::rsp_type   rsp_data
);
   import sjvp_pkg::*;

   logic [2:0] idx_ff;
   logic [2:0] total;
   logic       last;
   logic       fire;

   assign total = rd_data.nbytes + {2'd0, rd_data.done};
   assign last = (idx_ff + 3'd1) == total;
   assign rsp_valid = !empty;
   assign fire = rsp_valid && !rsp_stall;
   assign rd_en = fire && last;

   always_comb begin
      rsp_data = '0;
      rsp_data.last_of_run = last;
      if (idx_ff < rd_data.nbytes) begin
         rsp_data.out_byte = rd_data.bytes[idx_ff[1:0]];
         rsp_data.out_byte_valid = 1'b1;
      end else begin
         rsp_data.response_done = 1'b1;
         rsp_data.response_ok = rd_data.ok;
         rsp_data.verdict_pass = rd_data.pass;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
      end else if (fire) begin
         idx_ff <= last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (idx_ff < total))
      else $error("emit index past the entry");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.response_done) |-> rsp_data.last_of_run)
      else $error("status is not the last response of its request");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(idx_ff))
      else $error("emit index moved while stalled");
endmodule
`default_nettype wire

FILE: rtl/core/strict_json_verdict_parser.sv
// Top level of the strict JSON verdict parser: front, queue and result emitter.
// Depends on sjvp_pkg, sjvp_front, sjvp_queue and sjvp_back.
// Each accepted request's work entry is registered in the queue before the emitter can send its responses.
// Throughput: one request per cycle unless the queue is full; the emitter sends a request's responses one at a time.
// The queue of QueueDepth entries absorbs multi-byte escapes before requests stall.
// Synchronous active-high reset clears the parser state and empties the queue.
`default_nettype none
module strict_json_verdict_parser #(
   parameter int QueueDepth = sjvp_pkg::QueueDepth
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  sjvp_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output sjvp_pkg::rsp_type  rsp_data
);
   import sjvp_pkg::*;

   logic     wr_en, full, rd_en, empty;
   work_type wr_data, rd_data;

   sjvp_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .wr_en, .wr_data, .q_full(full)
   );

   sjvp_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset, .wr_en, .wr_data, .full, .rd_en, .rd_data, .empty
   );

   sjvp_back u_back (
      .clock, .reset, .rd_data, .empty, .rd_en, .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
`default_nettype wire
